FILE: hdl/rfb_pkg.sv
// rfb_pkg: types and constants shared by the frame builder modules
// no dependencies
`default_nettype none

package rfb_pkg;

  localparam logic [7:0]  PREAMBLE  = 8'hD3;
  localparam logic [23:0] CRC_POLY  = 24'h864CFB;
  localparam int          CMD_DEPTH = 4;
  localparam int          LEN_W     = 10;

  // one input beat
  typedef struct packed {
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] msg_len;
    logic             empty_frame;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
  } out_t;

  // classified work handed from front to back
  typedef struct packed {
    logic             start;
    logic             has_payload;
    logic             ends;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       payload_byte;
  } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/rfb_front.sv
// rfb_front: accepts input beats, tracks frame position, emits commands
// depends on rfb_pkg
`default_nettype none

module rfb_front import rfb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic accept,
  input  wire in_t  item,
  output cmd_t      cmd
);

  logic             inside_frame;
  logic [LEN_W-1:0] bytes_left;
  logic [LEN_W-1:0] len_eff;
  logic [LEN_W-1:0] left_next;

  always_comb begin
    len_eff   = item.empty_frame ? '0 : item.msg_len;
    left_next = inside_frame ? bytes_left - 1'b1 : len_eff - 1'b1;
    cmd.start          = !inside_frame;
    cmd.has_payload    = inside_frame || (len_eff != '0);
    cmd.ends           = (!inside_frame && len_eff == '0) || (left_next == '0);
    cmd.msg_len        = len_eff;
    cmd.payload_byte   = item.payload_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      bytes_left   <= '0;
    end else if (accept) begin
      inside_frame <= !cmd.ends;
      bytes_left   <= cmd.ends ? '0 : left_next;
    end
  end

`ifndef SYNTHESIS
  a_inside_has_bytes: assert property (@(posedge clk) disable iff (rst)
    inside_frame |-> bytes_left != '0) else $error("inside frame with no bytes left");
  a_end_leaves_frame: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.ends |=> !inside_frame) else $error("frame end did not close frame");
  a_mid_has_payload: assert property (@(posedge clk) disable iff (rst)
    accept && !cmd.start |-> cmd.has_payload) else $error("mid-frame command lacks payload");
`endif

endmodule

`default_nettype wire

FILE: hdl/rfb_cmd_fifo.sv
// rfb_cmd_fifo: short command queue between front and back
// depends on rfb_pkg
`default_nettype none

module rfb_cmd_fifo import rfb_pkg::*; #(
  parameter int Depth = CMD_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr,
  input  wire cmd_t wr_cmd,
  output logic      full,
  input  wire logic rd,
  output cmd_t      rd_cmd,
  output logic      nonempty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == FullCnt);
  assign nonempty = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rfb_back.sv
// rfb_back: expands commands into framed bytes with running crc-24q
// depends on rfb_pkg
`default_nettype none

module rfb_back import rfb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_pop,
  output logic      empty,
  input  wire logic pop,
  output out_t      result
);

  typedef enum logic [2:0] {
    PH_H0, PH_H1, PH_H2, PH_PAY, PH_C0, PH_C1, PH_C2
  } phase_t;

  function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        msb;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      msb = c[23];
      c   = {c[22:0], 1'b0};
      if (msb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  phase_t      phase;
  phase_t      eff_phase;
  phase_t      phase_next;
  logic        mid_cmd;
  logic [23:0] crc;
  logic        out_valid;
  out_t        out_reg;
  logic        emit;
  logic        last;
  logic [7:0]  byte_sel;

  assign empty  = !out_valid;
  assign result = out_reg;

  always_comb begin
    if (mid_cmd) begin
      eff_phase = phase;
    end else begin
      eff_phase = cmd.start ? PH_H0 : PH_PAY;
    end
    emit = cmd_valid && (!out_valid || pop);
    case (eff_phase)
      PH_H0:   byte_sel = PREAMBLE;
      PH_H1:   byte_sel = {6'b000000, cmd.msg_len[9:8]};
      PH_H2:   byte_sel = cmd.msg_len[7:0];
      PH_PAY:  byte_sel = cmd.payload_byte;
      PH_C0:   byte_sel = crc[23:16];
      PH_C1:   byte_sel = crc[15:8];
      PH_C2:   byte_sel = crc[7:0];
      default: byte_sel = '0;
    endcase
    case (eff_phase)
      PH_H0:   phase_next = PH_H1;
      PH_H1:   phase_next = PH_H2;
      PH_H2:   phase_next = cmd.has_payload ? PH_PAY : PH_C0;
      PH_PAY:  phase_next = PH_C0;
      PH_C0:   phase_next = PH_C1;
      PH_C1:   phase_next = PH_C2;
      default: phase_next = PH_H0;
    endcase
    last    = (eff_phase == PH_C2) || (eff_phase == PH_PAY && !cmd.ends);
    cmd_pop = emit && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_H0;
      mid_cmd   <= 1'b0;
      crc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && !emit) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        out_valid           <= 1'b1;
        out_reg.out_byte    <= byte_sel;
        out_reg.last_of_run <= last;
        out_reg.frame_done  <= (eff_phase == PH_C2);
        mid_cmd             <= !last;
        phase               <= phase_next;
        case (eff_phase)
          PH_H0:                crc <= crc_feed('0, byte_sel);
          PH_H1, PH_H2, PH_PAY: crc <= crc_feed(crc, byte_sel);
          default:              crc <= crc;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.frame_done |-> out_reg.last_of_run)
    else $error("frame end not marked last of run");
  a_mid_needs_cmd: assert property (@(posedge clk) disable iff (rst)
    mid_cmd |-> cmd_valid) else $error("command left queue mid-expansion");
  a_crc_runs_on: assert property (@(posedge clk) disable iff (rst)
    emit && eff_phase == PH_C0 |=> mid_cmd && phase == PH_C1)
    else $error("crc trailer cut short");
`endif

endmodule

`default_nettype wire

FILE: hdl/rtcm_frame_builder_unit.sv
// rtcm_frame_builder_unit: rtcm 3 framer with crc-24q trailer, top level
// depends on rfb_pkg, rfb_front, rfb_cmd_fifo, rfb_back
//
//   channel  direction  handshake             payload
//   item     in         push / full           in_t  (payload byte, length, empty flag)
//   result   out        pop / empty           out_t (byte, last of run, frame done)
//
// the back sends one byte per cycle unless pop stalls it or the queue is empty: a
// mid-frame beat gives one byte, the beat that closes a frame four (byte and three crc
// bytes), a frame start four, six or seven; the front takes one beat per cycle, while
// full is low, into a CmdDepth-deep command queue; full follows the queue, so a
// stalled result (pop low) holds the output register and backs it up
// synchronous reset clears frame position, queue and output valid; no clearing pass
`default_nettype none

module rtcm_frame_builder_unit import rfb_pkg::*; #(
  parameter int CmdDepth = CMD_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic      full,
  input  wire in_t  item,
  output logic      empty,
  input  wire logic pop,
  output out_t      result
);

  logic accept;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic head_valid;
  logic head_pop;

  // a beat is taken whenever the command queue has room
  assign accept = push && !full;

  rfb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cmd    (front_cmd)
  );

  rfb_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd       (head_pop),
    .rd_cmd   (head_cmd),
    .nonempty (head_valid)
  );

  // back expands the head command and drops it after its last byte
  rfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire

FILE: sim/rtcm_frame_builder_unit_tb.sv
// rtcm_frame_builder_unit_tb: self-checking bench for the rtcm 3 framer with crc-24q trailer
// depends on rfb_pkg (in_t, out_t) and rtcm_frame_builder_unit; predicts every framed byte
// and compares it with what the block pops out, with random idling on both sides

module rtcm_frame_builder_unit_tb;
  import rfb_pkg::*;

  // ---------------------------------------------------------------------------
  // frame tracker: rebuilds the framed byte stream from the input beats and
  // holds the bytes still owed by the block, oldest first
  // ---------------------------------------------------------------------------
  class rtcm_frame_tracker;
    localparam logic [7:0]  FRAME_PREAMBLE = 8'hD3;
    localparam logic [23:0] CRC24Q_POLY    = 24'h864CFB;

    out_t        owed_bytes[$];
    logic [23:0] crc_state;
    logic [9:0]  bytes_owed;
    bit          in_frame;
    int unsigned errors;

    function new();
      crc_state  = '0;
      bytes_owed = '0;
      in_frame   = 1'b0;
      errors     = 0;
    endfunction

    // msb-first crc-24q over one byte
    function void crc_shift(logic [7:0] b);
      logic [23:0] c;
      c = crc_state ^ {b, 16'h0000};
      for (int i = 0; i < 8; i++) begin
        c = c[23] ? ({c[22:0], 1'b0} ^ CRC24Q_POLY) : {c[22:0], 1'b0};
      end
      crc_state = c;
    endfunction

    function void owe(logic [7:0] b, logic done);
      out_t r;
      r.out_byte    = b;
      r.last_of_run = 1'b0;
      r.frame_done  = done;
      owed_bytes.push_back(r);
    endfunction

    function void owe_fed(logic [7:0] b);
      crc_shift(b);
      owe(b, 1'b0);
    endfunction

    // three crc bytes, high byte first, then back to waiting for a header
    function void owe_trailer();
      owe(crc_state[23:16], 1'b0);
      owe(crc_state[15:8], 1'b0);
      owe(crc_state[7:0], 1'b1);
      crc_state  = '0;
      bytes_owed = '0;
      in_frame   = 1'b0;
    endfunction

    function void note_item(in_t beat);
      logic [9:0] len;
      len = beat.empty_frame ? 10'd0 : beat.msg_len;
      if (!in_frame) begin
        crc_state = '0;
        owe_fed(FRAME_PREAMBLE);
        owe_fed({6'b000000, len[9:8]});
        owe_fed(len[7:0]);
        if (len == 10'd0) begin
          owe_trailer();
        end else begin
          owe_fed(beat.payload_byte);
          bytes_owed = len - 10'd1;
          if (bytes_owed == 10'd0) begin
            owe_trailer();
          end else begin
            in_frame = 1'b1;
          end
        end
      end else begin
        owe_fed(beat.payload_byte);
        bytes_owed = bytes_owed - 10'd1;
        if (bytes_owed == 10'd0) begin
          owe_trailer();
        end
      end
      owed_bytes[owed_bytes.size()-1].last_of_run = 1'b1;
    endfunction

    function int unsigned outstanding();
      return owed_bytes.size();
    endfunction

    task report(string what);
      $display("result mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (owed_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h, nothing owed", got.out_byte));
      end else begin
        want = owed_bytes.pop_front();
        if (got.out_byte !== want.out_byte) begin
          report($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
        end
        if (got.last_of_run !== want.last_of_run) begin
          report($sformatf("last_of_run got %b want %b (byte %02h)",
                           got.last_of_run, want.last_of_run, want.out_byte));
        end
        if (got.frame_done !== want.frame_done) begin
          report($sformatf("frame_done got %b want %b (byte %02h)",
                           got.frame_done, want.frame_done, want.out_byte));
        end
      end
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // bench knobs
  // ---------------------------------------------------------------------------
  localparam int unsigned IDLE_PCT     = 18;    // chance of a gap on either side
  localparam int unsigned HOLD_AT      = 380;   // results taken before the long stall
  localparam int unsigned HOLD_CYCLES  = 150;   // receiver hold-off length
  localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no beat before giving up
  localparam int unsigned TAIL_CYCLES  = 40;    // quiet time after the last result
  localparam int unsigned RANDOM_BEATS = 80;
  localparam int unsigned OPEN_BEATS   = 4;     // beats of the frame left open at the end

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic push  = 1'b0;
  logic pop   = 1'b0;
  in_t  item  = '0;
  logic full;
  logic empty;
  out_t result;

  rtcm_frame_tracker tracker = new();

  bit          no_gaps = 1'b0;  // both sides run flat out while set
  int unsigned beats_sent = 0;

  always #4 clk = ~clk;

  rtcm_frame_builder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // ---------------------------------------------------------------------------
  // receiver: checks every popped beat, idles at random, and holds off once
  // for a long stretch so the command queue fills and full rises
  // ---------------------------------------------------------------------------
  int unsigned results_taken = 0;
  int unsigned hold_left     = 0;
  bit          held_once     = 1'b0;

  always @(posedge clk) begin
    // outputs here are the values from just before this edge
    if (!rst && pop && !empty) begin
      tracker.check_result(result);
      results_taken++;
    end
    if (!held_once && results_taken >= HOLD_AT) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts edges at which no beat moves on either side
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sender tasks
  // ---------------------------------------------------------------------------

  // offer one beat; returns at the edge that took it, push still high
  task automatic send_beat(input in_t beat);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    item <= beat;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    tracker.note_item(beat);
    beats_sent++;
  endtask

  // one whole frame; header fields ride on the first beat only, later beats
  // carry noise in the length and empty flag that the block has to ignore;
  // a nonzero beat_cap below the beat count stops after that many beats and leaves the frame open
  task automatic send_frame(input int unsigned len, input bit flag_empty,
                            input int fixed_byte = -1,
                            input int unsigned beat_cap = 0);
    in_t         beat;
    int unsigned n;
    n = (flag_empty || len == 0) ? 1 : len;
    if (beat_cap != 0 && beat_cap < n) begin
      n = beat_cap;
    end
    for (int unsigned k = 0; k < n; k++) begin
      beat.payload_byte = (fixed_byte >= 0) ? fixed_byte[7:0] : 8'($urandom_range(255));
      beat.msg_len      = (k == 0) ? len[9:0] : 10'($urandom_range(1023));
      beat.empty_frame  = (k == 0) ? flag_empty : 1'($urandom_range(1));
      send_beat(beat);
    end
  endtask

  // stop offering and let the block drain every owed byte
  task automatic pause_until_drained();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // mostly short frames, some empty or zero length, a few longer ones
  task automatic send_random_frames(input int unsigned until_beats);
    int unsigned r;
    while (beats_sent < until_beats) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_frame($urandom_range(1023), 1'b1);
      end else if (r < 17) begin
        send_frame(0, 1'b0);
      end else if (r < 35) begin
        send_frame(1, 1'b0);
      end else if (r < 95) begin
        send_frame($urandom_range(20, 2), 1'b0);
      end else begin
        send_frame($urandom_range(60, 21), 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty flag wins over any length, zero length, single-byte
    // frames, byte extremes, and mid-frame beats with noisy flags
    send_frame(1023, 1'b1, 8'hFF);
    send_frame(0, 1'b1, 8'h00);
    send_frame(0, 1'b0, 8'hAB);
    send_frame(1, 1'b0, 8'hFF);
    send_frame(1, 1'b0, 8'h00);
    send_frame(2, 1'b0, 8'h5A);
    send_frame(3, 1'b0, 8'hFF);
    send_frame(5, 1'b0);
    send_frame(0, 1'b0, 8'h00);
    pause_until_drained();

    // long frame with only bit 8 of the high length part set, no idling on either side
    no_gaps = 1'b1;
    send_frame(260, 1'b0);
    no_gaps = 1'b0;
    pause_until_drained();

    // random frames; the receiver's long hold-off lands in here
    random_start = beats_sent;
    send_random_frames(random_start + RANDOM_BEATS);

    // start of the longest frame, both high length bits set, left open
    send_frame(1023, 1'b0, -1, OPEN_BEATS);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rfb_pkg.sv
hdl/rfb_front.sv
hdl/rfb_cmd_fifo.sv
hdl/rfb_back.sv
hdl/rtcm_frame_builder_unit.sv
sim/rtcm_frame_builder_unit_tb.sv
